@@ rtl/core/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg
// Types and constants shared by the cuckoo hash table controller and datapath.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int KEY_W       = 31;
	localparam int VAL_W       = 32;
	localparam int ACT_W       = 2;
	localparam int SLOT_W      = 8;
	localparam int ROUNDS_W    = 8;
	localparam int ROW_W       = 1 + KEY_W + VAL_W;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 48;

	localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 8'd10;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_NONE   = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		RD_FIRST,
		RD_SECOND,
		RD_CHAIN
	} rd_sel_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_CHECK,
		ST_EV_RD,
		ST_EV_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic    clr_en;
		logic    load_item;
		logic    mem_rd;
		rd_sel_t rd_sel;
		logic    cap_a;
		logic    wr_update;
		logic    wr_delete;
		logic    chain_start;
		logic    chain_rd;
		logic    chain_wr;
		logic    res_hit;
		logic    res_fail;
		logic    res_fresh;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic hit;
		logic rounds_zero;
		logic occ_used;
		logic last_round;
		logic clr_done;
		logic out_busy;
	} sts_t;

endpackage

@@ rtl/core/cuckoo_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// cuckoo_hash_table_top
// Single-table cuckoo hash map with two hashes and a bounded eviction chain.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_* carries one request per transaction (action, key, value).
//   Master stream m_* returns exactly one result per request (ok, value_out,
//   slot). The cfg_* channel writes max_rounds; write it only while idle.
//   After reset the table is cleared one slot per cycle; s_tready stays low
//   until it is done. max_rounds resets to 10. Requests are handled one at a
//   time over a single-port table memory: lookup, delete, update and misses
//   raise m_tvalid after two slot reads, a check and the output load. An
//   insert that runs the eviction chain adds a slot read and a slot write per
//   slot visited, up to 2*max_rounds slots.
//   s_tready returns high the cycle after the result is loaded. The result
//   sits in an output register, so the next request is taken while it waits;
//   if m_tready stays low, that next request holds before its own result.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_top #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cht_pkg::IN_TDATA_W-1:0]  s_tdata,  // action[1:0], key[32:2], value[64:33]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cht_pkg::OUT_TDATA_W-1:0] m_tdata,  // ok[0], value_out[32:1], slot[40:33]
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cht_pkg::ROUNDS_W-1:0]    cfg_data
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	cht_pkg::cmd_t cmd;
	cht_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cht_dpath #(
		.IDX_W (IDX_W)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

@@ rtl/core/cht_dpath.sv @@
// ----------------------------------------------------------------------------
// cht_dpath
// Table memory, item and eviction registers, result and output registers.
// ----------------------------------------------------------------------------
module cht_dpath #(
	parameter int IDX_W = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [cht_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [cht_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                             cfg_valid,
	input  logic [cht_pkg::ROUNDS_W-1:0]     cfg_data,
	input  cht_pkg::cmd_t                    cmd,
	output cht_pkg::sts_t                    sts
);

	localparam int DEPTH = 1 << IDX_W;
	localparam int KW    = cht_pkg::KEY_W;
	localparam int VW    = cht_pkg::VAL_W;
	localparam int RW    = cht_pkg::ROW_W;
	localparam int SW    = cht_pkg::SLOT_W;
	localparam int NW    = cht_pkg::ROUNDS_W;

	function automatic logic [IDX_W-1:0] hash_first(input logic [KW-1:0] k);
		hash_first = k[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] hash_second(input logic [KW-1:0] k);
		logic [KW+IDX_W-1:0] kx;
		kx          = {{IDX_W{1'b0}}, k};
		hash_second = kx[2*IDX_W-1:IDX_W];
	endfunction

	logic [RW-1:0]    mem [DEPTH];
	logic [RW-1:0]    rd_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [RW-1:0]    mem_wdata;
	logic [IDX_W-1:0] mem_raddr;

	cht_pkg::act_t    act_q;
	logic [KW-1:0]    key_q;
	logic [VW-1:0]    val_q;
	logic [KW-1:0]    ck_q;
	logic [VW-1:0]    cv_q;
	logic             hit_a_q;
	logic [VW-1:0]    val_a_q;
	logic [IDX_W-1:0] addr_q;
	logic             phase_q;
	logic [NW-1:0]    round_q;
	logic [NW-1:0]    max_rounds_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             res_ok_q;
	logic [VW-1:0]    res_val_q;
	logic [SW-1:0]    res_slot_q;
	logic             out_valid_q;
	logic [cht_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic             rd_used;
	logic [KW-1:0]    rd_key;
	logic [VW-1:0]    rd_val;
	logic             hit_b;
	logic [IDX_W-1:0] h1;
	logic [IDX_W-1:0] h2;
	logic [IDX_W-1:0] where;
	logic [IDX_W-1:0] chain_addr;
	logic [SW-1:0]    where_slot;
	logic [IDX_W+SW-1:0] where_x;
	logic [NW:0]      round_next;

	assign rd_used = rd_q[RW-1];
	assign rd_key  = rd_q[VW +: KW];
	assign rd_val  = rd_q[VW-1:0];

	assign h1         = hash_first(key_q);
	assign h2         = hash_second(key_q);
	assign hit_b      = rd_used && (rd_key == key_q);
	assign where      = hit_a_q ? h1 : h2;
	assign chain_addr = phase_q ? hash_second(ck_q) : hash_first(ck_q);
	assign where_x    = {{SW{1'b0}}, where};
	assign where_slot = where_x[SW-1:0];
	assign round_next = {1'b0, round_q} + 1'b1;

	always_comb begin
		case (cmd.rd_sel)
			cht_pkg::RD_FIRST:  mem_raddr = h1;
			cht_pkg::RD_SECOND: mem_raddr = h2;
			cht_pkg::RD_CHAIN:  mem_raddr = chain_addr;
			default:            mem_raddr = h1;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		if (cmd.clr_en) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
		end else if (cmd.wr_update) begin
			mem_we    = 1'b1;
			mem_waddr = where;
			mem_wdata = {1'b1, key_q, val_q};
		end else if (cmd.wr_delete) begin
			mem_we    = 1'b1;
			mem_waddr = where;
		end else if (cmd.chain_wr) begin
			mem_we    = 1'b1;
			mem_waddr = addr_q;
			mem_wdata = {1'b1, ck_q, cv_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// item, eviction and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q <= cht_pkg::act_t'(s_tdata[1:0]);
			key_q <= s_tdata[KW+1:2];
			val_q <= s_tdata[KW+VW+1:KW+2];
		end
		if (cmd.cap_a) begin
			hit_a_q <= rd_used && (rd_key == key_q);
			val_a_q <= rd_val;
		end
		if (cmd.chain_start) begin
			ck_q    <= key_q;
			cv_q    <= val_q;
			phase_q <= 1'b0;
			round_q <= '0;
		end else if (cmd.chain_wr) begin
			// carry the evicted pair to its other slot
			ck_q    <= rd_key;
			cv_q    <= rd_val;
			phase_q <= ~phase_q;
			if (phase_q) begin
				round_q <= round_next[NW-1:0];
			end
		end
		if (cmd.chain_rd) begin
			addr_q <= chain_addr;
		end
		if (cmd.res_hit) begin
			res_ok_q   <= 1'b1;
			res_slot_q <= where_slot;
			if (act_q == cht_pkg::ACT_LOOKUP) begin
				res_val_q <= hit_a_q ? val_a_q : rd_val;
			end else begin
				res_val_q <= '0;
			end
		end else if (cmd.res_fail || cmd.res_fresh) begin
			res_ok_q   <= cmd.res_fresh;
			res_slot_q <= '0;
			res_val_q  <= '0;
		end
		if (cmd.out_load) begin
			out_data_q <= {{(cht_pkg::OUT_TDATA_W-1-VW-SW){1'b0}},
				res_slot_q, res_val_q, res_ok_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rounds_q <= cht_pkg::ROUNDS_RESET;
			clr_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_rounds_q <= cfg_data;
			end
			if (cmd.clr_en) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		sts.act         = act_q;
		sts.hit         = hit_a_q || hit_b;
		sts.rounds_zero = (max_rounds_q == '0);
		sts.occ_used    = rd_used;
		sts.last_round  = phase_q && (round_next == {1'b0, max_rounds_q});
		sts.clr_done    = (clr_cnt_q == {IDX_W{1'b1}});
		sts.out_busy    = out_valid_q && !m_tready;
	end

endmodule

@@ rtl/core/cht_ctrl.sv @@
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer for table clear, probe, update/delete and the eviction chain.
// ----------------------------------------------------------------------------
module cht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  cht_pkg::sts_t sts,
	output cht_pkg::cmd_t cmd
);

	cht_pkg::state_t state_q;
	cht_pkg::state_t state_d;
	logic            valid_hit;

	assign valid_hit = sts.hit && (sts.act != cht_pkg::ACT_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cht_pkg::ST_CLEAR: begin
				if (sts.clr_done) begin
					state_d = cht_pkg::ST_IDLE;
				end
			end
			cht_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = cht_pkg::ST_RD_A;
				end
			end
			cht_pkg::ST_RD_A:  state_d = cht_pkg::ST_RD_B;
			cht_pkg::ST_RD_B:  state_d = cht_pkg::ST_CHECK;
			cht_pkg::ST_CHECK: begin
				if (!valid_hit && sts.act == cht_pkg::ACT_INSERT && !sts.rounds_zero) begin
					state_d = cht_pkg::ST_EV_RD;
				end else begin
					state_d = cht_pkg::ST_FINISH;
				end
			end
			cht_pkg::ST_EV_RD: state_d = cht_pkg::ST_EV_WR;
			cht_pkg::ST_EV_WR: begin
				if (!sts.occ_used || sts.last_round) begin
					state_d = cht_pkg::ST_FINISH;
				end else begin
					state_d = cht_pkg::ST_EV_RD;
				end
			end
			cht_pkg::ST_FINISH: begin
				if (!sts.out_busy) begin
					state_d = cht_pkg::ST_IDLE;
				end
			end
			default: state_d = cht_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = cht_pkg::RD_FIRST;
		s_tready = 1'b0;
		case (state_q)
			cht_pkg::ST_CLEAR: cmd.clr_en = 1'b1;
			cht_pkg::ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.load_item = s_tvalid;
			end
			cht_pkg::ST_RD_A: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = cht_pkg::RD_FIRST;
			end
			cht_pkg::ST_RD_B: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = cht_pkg::RD_SECOND;
				cmd.cap_a  = 1'b1;
			end
			cht_pkg::ST_CHECK: begin
				if (valid_hit) begin
					cmd.res_hit   = 1'b1;
					cmd.wr_update = (sts.act == cht_pkg::ACT_INSERT);
					cmd.wr_delete = (sts.act == cht_pkg::ACT_DELETE);
				end else if (sts.act == cht_pkg::ACT_INSERT && !sts.rounds_zero) begin
					cmd.chain_start = 1'b1;
				end else begin
					cmd.res_fail = 1'b1;
				end
			end
			cht_pkg::ST_EV_RD: begin
				cmd.mem_rd   = 1'b1;
				cmd.rd_sel   = cht_pkg::RD_CHAIN;
				cmd.chain_rd = 1'b1;
			end
			cht_pkg::ST_EV_WR: begin
				cmd.chain_wr = 1'b1;
				if (!sts.occ_used) begin
					cmd.res_fresh = 1'b1;
				end else if (sts.last_round) begin
					// give up, drop the pair in hand
					cmd.res_fail = 1'b1;
				end
			end
			cht_pkg::ST_FINISH: cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

endmodule
